### src/rdc_pkg.sv
// Package for the radix digit calculator: field widths, operation codes,
// the controller-to-datapath command and status types, and the power-of-ten table.
// Depends on nothing.
package rdc_pkg;

  localparam int OPERAND_DIGITS_DEF = 8;

  localparam int FUNC_W    = 2;
  localparam int OPND_W    = 27;
  localparam int RADIX_W   = 4;
  localparam int RES_W     = 58;
  localparam int BIN_W     = 32;
  localparam int MAG_W     = 2 * BIN_W;
  localparam int RES_DIGITS = 17;
  localparam int DIG_W     = $clog2(RES_DIGITS + 1);
  localparam int DIV_CHUNK = 8;
  localparam int DIV_STEPS = MAG_W / DIV_CHUNK;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd8;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd9;
  localparam logic [RES_W-1:0]   RESULT_SAT  = 58'd99999999999999999;
  localparam logic [BIN_W-1:0]   RECIP_TEN   = 32'hCCCCCCCD;
  localparam int                 RECIP_SHIFT = 35;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  typedef struct packed {
    logic             load_in;
    logic             cv_step;
    logic             cv_extract;
    logic             cv_accum;
    logic             cv_switch;
    logic             op_exec;
    logic             div_step;
    logic             od_step;
    logic             od_digit;
    logic             out_load;
    logic [DIG_W-1:0] digit_idx;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  b_zero;
    logic  mag_zero;
  } sts_t;

  function automatic logic [RES_W-1:0] pow10(input logic [DIG_W-1:0] k);
    logic [RES_W-1:0] w;
    case (k)
      5'd0:    w = 58'd1;
      5'd1:    w = 58'd10;
      5'd2:    w = 58'd100;
      5'd3:    w = 58'd1000;
      5'd4:    w = 58'd10000;
      5'd5:    w = 58'd100000;
      5'd6:    w = 58'd1000000;
      5'd7:    w = 58'd10000000;
      5'd8:    w = 58'd100000000;
      5'd9:    w = 58'd1000000000;
      5'd10:   w = 58'd10000000000;
      5'd11:   w = 58'd100000000000;
      5'd12:   w = 58'd1000000000000;
      5'd13:   w = 58'd10000000000000;
      5'd14:   w = 58'd100000000000000;
      5'd15:   w = 58'd1000000000000000;
      5'd16:   w = 58'd10000000000000000;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

### src/radix_digit_calculator.sv
// Radix digit calculator: arithmetic on base-2 to base-9 numbers written as decimal digits.
// Top level; instantiates rdc_ctrl and rdc_datapath and depends on rdc_pkg.
//
// Usage: an item (func_i, operand_a_i, operand_b_i) is transferred when in_valid_i is high
// and in_stall_o is low. The result (result_digits_o, divide_error_o) is transferred when
// out_valid_o is high and out_stall_i is low. The radix register is written through
// radix_we_i and radix_wdata_i; the user must write it only while the block is idle, which
// the block itself does not enforce; reset sets it to eight. One item is worked on at a time.
// Each operand is converted by a shared divide-by-ten unit, then the operation is done,
// followed for a division with a nonzero divisor by the one-bit-per-cycle divider. The
// result is then converted one base-radix digit at a time in the divide-by-radix unit
// that retires eight bits per cycle; at most 17 result digits are produced. The next
// item can be transferred in the same cycle as the result is offered.
// If the receiver stalls, the next result waits inside the block until the register is
// free, and no further item is taken meanwhile.
// After reset no result is pending and the block is ready for an item.
module radix_digit_calculator #(
  parameter int OPERAND_DIGITS = rdc_pkg::OPERAND_DIGITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              radix_we_i,
  input  logic [rdc_pkg::RADIX_W-1:0]       radix_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rdc_pkg::FUNC_W-1:0]        func_i,
  input  logic [rdc_pkg::OPND_W-1:0]        operand_a_i,
  input  logic [rdc_pkg::OPND_W-1:0]        operand_b_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rdc_pkg::RES_W-1:0]  result_digits_o,
  output logic                              divide_error_o
);

  rdc_pkg::cmd_t cmd;
  rdc_pkg::sts_t sts;

  rdc_ctrl #(
    .OPERAND_DIGITS(OPERAND_DIGITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rdc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .radix_we_i     (radix_we_i),
    .radix_wdata_i  (radix_wdata_i),
    .func_i         (func_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_digits_o(result_digits_o),
    .divide_error_o (divide_error_o)
  );

endmodule

### src/rdc_datapath.sv
// Datapath of the radix digit calculator: radix register, operand conversion,
// arithmetic with a bit-serial divider, digit-serial result conversion and output register.
// Depends on rdc_pkg.
module rdc_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               radix_we_i,
  input  logic [rdc_pkg::RADIX_W-1:0]        radix_wdata_i,
  input  logic [rdc_pkg::FUNC_W-1:0]         func_i,
  input  logic [rdc_pkg::OPND_W-1:0]         operand_a_i,
  input  logic [rdc_pkg::OPND_W-1:0]         operand_b_i,
  input  rdc_pkg::cmd_t                      cmd_i,
  output rdc_pkg::sts_t                      sts_o,
  output logic signed [rdc_pkg::RES_W-1:0]   result_digits_o,
  output logic                               divide_error_o
);

  localparam int BIN_W   = rdc_pkg::BIN_W;
  localparam int MAG_W   = rdc_pkg::MAG_W;
  localparam int RES_W   = rdc_pkg::RES_W;
  localparam int OPND_W  = rdc_pkg::OPND_W;
  localparam int RADIX_W = rdc_pkg::RADIX_W;
  localparam int CHUNK   = rdc_pkg::DIV_CHUNK;
  localparam int PROD_W  = OPND_W + BIN_W;
  localparam int Q10_W   = PROD_W - rdc_pkg::RECIP_SHIFT;

  logic [RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0] r_eff;

  rdc_pkg::func_e     func_q;
  logic [OPND_W-1:0]  opb_q;
  logic [OPND_W-1:0]  cv_val_q;
  logic [3:0]         cv_dig_q;
  logic [BIN_W-1:0]   cv_acc_q;
  logic [BIN_W-1:0]   cv_wgt_q;
  logic [BIN_W-1:0]   a_bin_q;
  logic [MAG_W-1:0]   mag_q;
  logic [BIN_W-1:0]   dv_rem_q;
  logic               neg_q;
  logic               err_q;
  logic [3:0]         od_rem_q;
  logic [RES_W-1:0]   acc_q;
  logic [RES_W-1:0]   out_val_q;
  logic               out_err_q;

  logic [PROD_W-1:0]  recip_prod;
  logic [Q10_W-1:0]   q10;
  logic [OPND_W-1:0]  rem10;
  logic [BIN_W-1:0]   dig_term;
  logic [BIN_W-1:0]   wgt_next;
  logic [MAG_W-1:0]   mul_p;
  logic [BIN_W:0]     dv_t;
  logic [BIN_W:0]     dv_diff;
  logic               dv_ge;
  logic [CHUNK-1:0]   od_qbits;
  logic [3:0]         od_rem_next;
  logic [RES_W-1:0]   pow_w;
  logic [RES_W-1:0]   pow_term;
  logic [RES_W-1:0]   final_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rdc_pkg::RADIX_RESET;
    end else if (radix_we_i) begin
      radix_q <= radix_wdata_i;
    end
  end

  always_comb begin
    if (radix_q < rdc_pkg::RADIX_MIN) begin
      r_eff = rdc_pkg::RADIX_MIN;
    end else if (radix_q > rdc_pkg::RADIX_MAX) begin
      r_eff = rdc_pkg::RADIX_MAX;
    end else begin
      r_eff = radix_q;
    end
  end

  // Division by ten through a reciprocal multiply, exact for 32-bit values.
  assign recip_prod = PROD_W'(cv_val_q) * PROD_W'(rdc_pkg::RECIP_TEN);
  assign q10        = recip_prod[PROD_W-1:rdc_pkg::RECIP_SHIFT];
  assign rem10      = cv_val_q - OPND_W'({q10, 3'b000}) - OPND_W'({q10, 1'b0});
  assign dig_term   = BIN_W'(cv_dig_q * cv_wgt_q);
  assign wgt_next   = BIN_W'(cv_wgt_q * r_eff);

  assign mul_p   = MAG_W'(a_bin_q) * MAG_W'(cv_acc_q);
  assign dv_t    = {dv_rem_q, mag_q[BIN_W-1]};
  assign dv_diff = dv_t - {1'b0, cv_acc_q};
  assign dv_ge   = (dv_t >= {1'b0, cv_acc_q});

  always_comb begin
    logic [3:0] rem;
    logic [4:0] t;
    rem = od_rem_q;
    od_qbits = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      t = {rem, mag_q[MAG_W-CHUNK+i]};
      if (t >= {1'b0, r_eff}) begin
        od_qbits[i] = 1'b1;
        rem = 4'(t - {1'b0, r_eff});
      end else begin
        rem = t[3:0];
      end
    end
    od_rem_next = rem;
  end

  assign pow_w = rdc_pkg::pow10(cmd_i.digit_idx);

  always_comb begin
    pow_term = '0;
    for (int i = 0; i < 4; i++) begin
      if (od_rem_q[i]) begin
        pow_term = pow_term + (pow_w << i);
      end
    end
  end

  assign final_mag = (mag_q == '0) ? acc_q : rdc_pkg::RESULT_SAT;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q   <= rdc_pkg::func_e'(func_i);
      opb_q    <= operand_b_i;
      cv_val_q <= operand_a_i;
      cv_dig_q <= '0;
      cv_acc_q <= '0;
      cv_wgt_q <= BIN_W'(1);
    end
    if (cmd_i.cv_step) begin
      if (cmd_i.cv_extract) begin
        cv_val_q <= OPND_W'(q10);
        cv_dig_q <= rem10[3:0];
      end
      if (cmd_i.cv_accum) begin
        cv_acc_q <= cv_acc_q + dig_term;
        cv_wgt_q <= wgt_next;
      end
    end
    if (cmd_i.cv_switch) begin
      a_bin_q  <= cv_acc_q;
      cv_val_q <= opb_q;
      cv_dig_q <= '0;
      cv_acc_q <= '0;
      cv_wgt_q <= BIN_W'(1);
    end
    if (cmd_i.op_exec) begin
      neg_q    <= (func_q == rdc_pkg::FUNC_SUB) && (a_bin_q < cv_acc_q);
      err_q    <= (func_q == rdc_pkg::FUNC_DIV) && (cv_acc_q == '0);
      dv_rem_q <= '0;
      acc_q    <= '0;
      od_rem_q <= '0;
      case (func_q)
        rdc_pkg::FUNC_ADD: begin
          mag_q <= MAG_W'(a_bin_q) + MAG_W'(cv_acc_q);
        end
        rdc_pkg::FUNC_SUB: begin
          if (a_bin_q >= cv_acc_q) begin
            mag_q <= MAG_W'(a_bin_q - cv_acc_q);
          end else begin
            mag_q <= MAG_W'(cv_acc_q - a_bin_q);
          end
        end
        rdc_pkg::FUNC_MUL: begin
          mag_q <= mul_p;
        end
        default: begin
          if (cv_acc_q == '0) begin
            mag_q <= '0;
          end else begin
            mag_q <= MAG_W'(a_bin_q);
          end
        end
      endcase
    end
    if (cmd_i.div_step) begin
      dv_rem_q <= dv_ge ? dv_diff[BIN_W-1:0] : dv_t[BIN_W-1:0];
      mag_q    <= {mag_q[MAG_W-1:BIN_W], mag_q[BIN_W-2:0], dv_ge};
    end
    if (cmd_i.od_step) begin
      mag_q    <= {mag_q[MAG_W-CHUNK-1:0], od_qbits};
      od_rem_q <= od_rem_next;
    end
    if (cmd_i.od_digit) begin
      acc_q    <= acc_q + pow_term;
      od_rem_q <= '0;
    end
    if (cmd_i.out_load) begin
      out_val_q <= neg_q ? (RES_W'(0) - final_mag) : final_mag;
      out_err_q <= err_q;
    end
  end

  assign sts_o.func     = func_q;
  assign sts_o.b_zero   = (cv_acc_q == '0);
  assign sts_o.mag_zero = (mag_q == '0);

  assign result_digits_o = out_val_q;
  assign divide_error_o  = out_err_q;

endmodule

### src/rdc_ctrl.sv
// Controller of the radix digit calculator: sequences conversion, arithmetic and
// result conversion, and owns the input stall and output valid of both channels.
// Depends on rdc_pkg.
module rdc_ctrl #(
  parameter int OPERAND_DIGITS = rdc_pkg::OPERAND_DIGITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  rdc_pkg::sts_t sts_i,
  output rdc_pkg::cmd_t cmd_o
);

  localparam int CV_W  = $clog2(OPERAND_DIGITS + 1);
  localparam int DV_W  = $clog2(rdc_pkg::BIN_W);
  localparam int OD_W  = $clog2(rdc_pkg::DIV_STEPS);
  localparam int CNT_W = (CV_W > DV_W) ? ((CV_W > OD_W) ? CV_W : OD_W)
                                       : ((DV_W > OD_W) ? DV_W : OD_W);
  localparam int DIG_W = rdc_pkg::DIG_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV_A,
    ST_SWITCH,
    ST_CONV_B,
    ST_EXEC,
    ST_DIV,
    ST_OUT_CHECK,
    ST_OUT_DIV,
    ST_OUT_DIGIT,
    ST_FINISH
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIG_W-1:0] dig_q;
  logic             out_valid_q;
  logic             slot_free;
  logic             cv_last;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign cv_last   = (cnt_q == CNT_W'(OPERAND_DIGITS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_FINISH && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cnt_q   <= '0;
            state_q <= ST_CONV_A;
          end
        end
        ST_CONV_A, ST_CONV_B: begin
          if (cv_last) begin
            cnt_q   <= '0;
            state_q <= (state_q == ST_CONV_A) ? ST_SWITCH : ST_EXEC;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_SWITCH: begin
          state_q <= ST_CONV_B;
        end
        ST_EXEC: begin
          dig_q <= '0;
          cnt_q <= '0;
          if (sts_i.func == rdc_pkg::FUNC_DIV && !sts_i.b_zero) begin
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_OUT_CHECK;
          end
        end
        ST_DIV: begin
          if (cnt_q == CNT_W'(rdc_pkg::BIN_W - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_OUT_CHECK;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_OUT_CHECK: begin
          cnt_q <= '0;
          if (sts_i.mag_zero || dig_q == DIG_W'(rdc_pkg::RES_DIGITS)) begin
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_OUT_DIV;
          end
        end
        ST_OUT_DIV: begin
          if (cnt_q == CNT_W'(rdc_pkg::DIV_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_OUT_DIGIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_OUT_DIGIT: begin
          dig_q   <= dig_q + 1'b1;
          state_q <= ST_OUT_CHECK;
        end
        ST_FINISH: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.digit_idx  = dig_q;
    cmd_o.cv_extract = (cnt_q < CNT_W'(OPERAND_DIGITS));
    cmd_o.cv_accum   = (cnt_q != '0);
    case (state_q)
      ST_IDLE:      cmd_o.load_in   = in_valid_i;
      ST_CONV_A:    cmd_o.cv_step   = 1'b1;
      ST_CONV_B:    cmd_o.cv_step   = 1'b1;
      ST_SWITCH:    cmd_o.cv_switch = 1'b1;
      ST_EXEC:      cmd_o.op_exec   = 1'b1;
      ST_DIV:       cmd_o.div_step  = 1'b1;
      ST_OUT_DIV:   cmd_o.od_step   = 1'b1;
      ST_OUT_DIGIT: cmd_o.od_digit  = 1'b1;
      ST_FINISH:    cmd_o.out_load  = slot_free;
      default:      cmd_o.load_in   = 1'b0;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
